// ----- sv/uart_register_interface_macros.svh -----
`ifndef UART_REGISTER_INTERFACE_MACROS_SVH
`define UART_REGISTER_INTERFACE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define URI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define URI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/uart_ri_pkg.sv -----
package uart_ri_pkg;

    typedef enum logic [1:0] {
        KIND_RX     = 2'd0,
        KIND_READ   = 2'd1,
        KIND_WRITE  = 2'd2,
        KIND_SELECT = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PARITY_NONE = 2'd0,
        PARITY_ODD  = 2'd1,
        PARITY_EVEN = 2'd2
    } parity_t;

    localparam logic [7:0] STAT_THRE = 8'h80;
    localparam logic [7:0] STAT_TSRE = 8'h40;
    localparam logic [7:0] STAT_OE   = 8'h02;
    localparam logic [7:0] STAT_DA   = 8'h01;

    localparam logic [7:0] CTL_TR  = 8'h80;
    localparam logic [7:0] CTL_BRK = 8'h40;
    localparam logic [7:0] CTL_IE  = 8'h20;
    localparam logic [7:0] CTL_FMT = 8'h1C;
    localparam logic [7:0] CTL_EPE = 8'h02;
    localparam logic [7:0] CTL_PI  = 8'h01;

    localparam int unsigned CTL_FMT_SHIFT = 2;

endpackage

// ----- sv/uart_ri_if.sv -----
interface uart_ri_req_if;
    import uart_ri_pkg::*;

    logic       valid;
    logic       ready;
    kind_t      kind;
    logic [7:0] data;
    logic       select_level;

    modport source (output valid, kind, data, select_level, input ready);
    modport sink   (input valid, kind, data, select_level, output ready);
endinterface

interface uart_ri_rsp_if;
    import uart_ri_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       read_valid;
    logic [7:0] tx_data;
    logic       tx_valid;
    logic       irq_level;
    parity_t    parity_mode;
    logic [2:0] word_format;
    logic       break_level;
    logic       transmit_request;

    modport source (
        output valid, read_data, read_valid, tx_data, tx_valid, irq_level,
               parity_mode, word_format, break_level, transmit_request,
        input  ready
    );
    modport sink (
        input  valid, read_data, read_valid, tx_data, tx_valid, irq_level,
               parity_mode, word_format, break_level, transmit_request,
        output ready
    );
endinterface

// ----- sv/uart_register_interface.sv -----
// A request passes through the input register, then the response register.
// Throughput: one request per cycle; the input register and the response
// register each take a new transfer whenever the stage after them moves.
// Reset (rst_n low, asynchronous): all flags, holding and control state clear
// to zero, parity none, both pipeline registers empty.
`include "uart_register_interface_macros.svh"

module uart_register_interface (
    input  logic          clk,
    input  logic          rst_n,
    uart_ri_req_if.sink   req,
    uart_ri_rsp_if.source rsp
);
    import uart_ri_pkg::*;

    logic       in_valid_reg;
    kind_t      in_kind_reg;
    logic [7:0] in_data_reg;
    logic       in_sel_reg;

    logic       advance;
    logic       fire;

    logic       da_reg, da_next;
    logic       ov_reg, ov_next;
    logic       ie_reg, ie_next;
    logic       ip_reg, ip_next;
    logic       brk_reg, brk_next;
    logic       tr_reg, tr_next;
    logic       sel_reg, sel_next;
    logic [7:0] rhr_reg, rhr_next;
    parity_t    par_reg, par_next;
    logic [2:0] fmt_reg, fmt_next;

    logic [7:0] rd_next;
    logic       rv_next;
    logic [7:0] td_next;
    logic       tv_next;

    logic       out_valid_reg;
    logic [7:0] out_rd_reg;
    logic       out_rv_reg;
    logic [7:0] out_td_reg;
    logic       out_tv_reg;
    logic       out_irq_reg;
    parity_t    out_par_reg;
    logic [2:0] out_fmt_reg;
    logic       out_brk_reg;
    logic       out_tr_reg;

    assign advance   = !out_valid_reg || rsp.ready;
    assign fire      = in_valid_reg && advance;
    assign req.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            in_kind_reg <= req.kind;
            in_data_reg <= req.data;
            in_sel_reg  <= req.select_level;
        end
    end

    always_comb
    begin
        da_next  = da_reg;
        ov_next  = ov_reg;
        ie_next  = ie_reg;
        ip_next  = ip_reg;
        brk_next = brk_reg;
        tr_next  = tr_reg;
        sel_next = sel_reg;
        rhr_next = rhr_reg;
        par_next = par_reg;
        fmt_next = fmt_reg;
        rd_next  = 8'h00;
        rv_next  = 1'b0;
        td_next  = 8'h00;
        tv_next  = 1'b0;

        unique case (in_kind_reg)
            KIND_RX:
            begin
                if (da_reg)
                begin
                    ov_next = 1'b1;
                end
                rhr_next = in_data_reg;
                da_next  = 1'b1;
                if (ie_reg)
                begin
                    ip_next = 1'b1;
                end
            end
            KIND_READ:
            begin
                rv_next = 1'b1;
                if (sel_reg)
                begin
                    rd_next = STAT_THRE | STAT_TSRE
                            | (ov_reg ? STAT_OE : 8'h00)
                            | (da_reg ? STAT_DA : 8'h00);
                    ip_next = 1'b0;
                end
                else
                begin
                    rd_next = rhr_reg;
                    da_next = 1'b0;
                    ov_next = 1'b0;
                end
            end
            KIND_WRITE:
            begin
                if (sel_reg)
                begin
                    // drop a control write that asks for transmit while one is requested
                    if (!(tr_reg && ((in_data_reg & CTL_TR) != 8'h00)))
                    begin
                        if ((in_data_reg & CTL_PI) != 8'h00)
                        begin
                            par_next = PARITY_NONE;
                        end
                        else if ((in_data_reg & CTL_EPE) != 8'h00)
                        begin
                            par_next = PARITY_EVEN;
                        end
                        else
                        begin
                            par_next = PARITY_ODD;
                        end
                        fmt_next = 3'((in_data_reg & CTL_FMT) >> CTL_FMT_SHIFT);
                        ie_next  = (in_data_reg & CTL_IE) != 8'h00;
                        brk_next = (in_data_reg & CTL_BRK) != 8'h00;
                        tr_next  = (in_data_reg & CTL_TR) != 8'h00;
                        if ((in_data_reg & CTL_IE) == 8'h00)
                        begin
                            ip_next = 1'b0;
                        end
                    end
                end
                else
                begin
                    td_next = in_data_reg;
                    tv_next = 1'b1;
                    ip_next = 1'b0;
                end
            end
            KIND_SELECT:
            begin
                sel_next = in_sel_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            da_reg  <= 1'b0;
            ov_reg  <= 1'b0;
            ie_reg  <= 1'b0;
            ip_reg  <= 1'b0;
            brk_reg <= 1'b0;
            tr_reg  <= 1'b0;
            sel_reg <= 1'b0;
            rhr_reg <= 8'h00;
            par_reg <= PARITY_NONE;
            fmt_reg <= 3'd0;
        end
        else if (fire)
        begin
            da_reg  <= da_next;
            ov_reg  <= ov_next;
            ie_reg  <= ie_next;
            ip_reg  <= ip_next;
            brk_reg <= brk_next;
            tr_reg  <= tr_next;
            sel_reg <= sel_next;
            rhr_reg <= rhr_next;
            par_reg <= par_next;
            fmt_reg <= fmt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_rd_reg  <= rd_next;
            out_rv_reg  <= rv_next;
            out_td_reg  <= td_next;
            out_tv_reg  <= tv_next;
            out_irq_reg <= ip_next;
            out_par_reg <= par_next;
            out_fmt_reg <= fmt_next;
            out_brk_reg <= brk_next;
            out_tr_reg  <= tr_next;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.read_data        = out_rd_reg;
    assign rsp.read_valid       = out_rv_reg;
    assign rsp.tx_data          = out_td_reg;
    assign rsp.tx_valid         = out_tv_reg;
    assign rsp.irq_level        = out_irq_reg;
    assign rsp.parity_mode      = out_par_reg;
    assign rsp.word_format      = out_fmt_reg;
    assign rsp.break_level      = out_brk_reg;
    assign rsp.transmit_request = out_tr_reg;

    `URI_ASSERT_NOW(a_ov_needs_da, ov_reg, da_reg, "overrun set without data available")
    `URI_ASSERT_NOW(a_ip_needs_ie, ip_reg, ie_reg, "interrupt pending while disabled")
    `URI_ASSERT_NOW(a_rd_tx_excl, out_valid_reg, !(out_rv_reg && out_tv_reg), "read and transmit in one response")
    `URI_ASSERT_NEXT(a_tx_write, fire && in_kind_reg == KIND_WRITE && !sel_reg, out_valid_reg && out_tv_reg, "transmit write gave no transmit")
    `URI_ASSERT_NEXT(a_rx_sets_da, fire && in_kind_reg == KIND_RX, da_reg && rhr_reg == $past(in_data_reg), "received character not held")

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import uart_ri_pkg::*;

    localparam int unsigned RANDOM_EVENTS = 825;
    localparam int unsigned IDLE_LIMIT    = 4000;
    localparam int unsigned SHOWN_ERRORS  = 10;

    typedef struct {
        kind_t      kind;
        logic [7:0] data;
        logic       select_level;
        bit         drain_first;
    } uart_event_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       read_valid;
        logic [7:0] tx_data;
        logic       tx_valid;
        logic       irq_level;
        parity_t    parity_mode;
        logic [2:0] word_format;
        logic       break_level;
        logic       transmit_request;
    } uart_rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    uart_ri_req_if req_if ();
    uart_ri_rsp_if rsp_if ();

    uart_register_interface i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if.sink),
        .rsp   (rsp_if.source)
    );

    // register mirror
    logic       rx_full     = 1'b0;
    logic       rx_overrun  = 1'b0;
    logic       irq_en      = 1'b0;
    logic       irq_pend    = 1'b0;
    logic       brk         = 1'b0;
    logic       tx_req      = 1'b0;
    logic       sel_status  = 1'b0;
    logic [7:0] rx_hold     = 8'h00;
    logic [7:0] tx_hold     = 8'h00;
    parity_t    parity      = PARITY_NONE;
    logic [2:0] fmt         = 3'd0;

    uart_event_t event_backlog[$];
    uart_rsp_t   due_responses[$];
    uart_event_t next_event;
    uart_rsp_t   got_rsp;
    uart_rsp_t   want_rsp;

    int unsigned send_gap    = 0;
    int unsigned send_calm   = 0;
    int unsigned recv_gap    = 0;
    int unsigned recv_calm   = 0;
    int unsigned idle_cycles = 0;
    int unsigned n_sent      = 0;
    int unsigned n_checked   = 0;
    int unsigned n_errors    = 0;
    int unsigned n_reads     = 0;
    int unsigned n_tx        = 0;
    int unsigned n_locked    = 0;
    int unsigned n_overruns  = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned draw_pause(inout int unsigned calm_left);
        int unsigned roll;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 4)
        begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic uart_rsp_t advance_uart_regs(kind_t kind, logic [7:0] data,
                                                    logic select_level);
        uart_rsp_t r;
        r = '0;
        case (kind)
            KIND_RX:
            begin
                if (rx_full)
                begin
                    rx_overrun = 1'b1;
                    n_overruns++;
                end
                rx_hold = data;
                rx_full = 1'b1;
                if (irq_en && !irq_pend)
                    irq_pend = 1'b1;
            end
            KIND_READ:
            begin
                r.read_valid = 1'b1;
                n_reads++;
                if (sel_status)
                begin
                    r.read_data = STAT_THRE | STAT_TSRE
                                | (rx_overrun ? STAT_OE : 8'h00)
                                | (rx_full ? STAT_DA : 8'h00);
                    if (irq_en && irq_pend)
                        irq_pend = 1'b0;
                end
                else
                begin
                    r.read_data = rx_hold;
                    rx_full = 1'b0;
                    rx_overrun = 1'b0;
                end
            end
            KIND_WRITE:
            begin
                if (sel_status)
                begin
                    if (tx_req && (data & CTL_TR) != 8'h00)
                        n_locked++;
                    else
                    begin
                        if ((data & CTL_PI) != 8'h00)
                            parity = PARITY_NONE;
                        else if ((data & CTL_EPE) != 8'h00)
                            parity = PARITY_EVEN;
                        else
                            parity = PARITY_ODD;
                        fmt = 3'((data & CTL_FMT) >> CTL_FMT_SHIFT);
                        irq_en = (data & CTL_IE) != 8'h00;
                        brk = (data & CTL_BRK) != 8'h00;
                        tx_req = (data & CTL_TR) != 8'h00;
                        if (!irq_en)
                            irq_pend = 1'b0;
                    end
                end
                else
                begin
                    tx_hold = data;
                    r.tx_data = tx_hold;
                    r.tx_valid = 1'b1;
                    n_tx++;
                    if (irq_en && irq_pend)
                        irq_pend = 1'b0;
                end
            end
            KIND_SELECT:
                sel_status = select_level;
        endcase
        r.irq_level = irq_pend;
        r.parity_mode = parity;
        r.word_format = fmt;
        r.break_level = brk;
        r.transmit_request = tx_req;
        return r;
    endfunction

    task automatic queue_event(kind_t kind, logic [7:0] data, logic select_level,
                               bit drain_first = 1'b0);
        uart_event_t e;
        e.kind = kind;
        e.data = data;
        e.select_level = select_level;
        e.drain_first = drain_first;
        event_backlog.push_back(e);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_if.valid && req_if.ready)
            begin
                due_responses.push_back(advance_uart_regs(req_if.kind, req_if.data,
                                                          req_if.select_level));
                n_sent++;
            end
            if (!req_if.valid || req_if.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_if.valid <= 1'b0;
                end
                else if (event_backlog.size() > 0 &&
                         !(event_backlog[0].drain_first && due_responses.size() > 0))
                begin
                    next_event = event_backlog.pop_front();
                    req_if.valid <= 1'b1;
                    req_if.kind <= next_event.kind;
                    req_if.data <= next_event.data;
                    req_if.select_level <= next_event.select_level;
                    send_gap = draw_pause(send_calm);
                end
                else
                    req_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                got_rsp.read_data = rsp_if.read_data;
                got_rsp.read_valid = rsp_if.read_valid;
                got_rsp.tx_data = rsp_if.tx_data;
                got_rsp.tx_valid = rsp_if.tx_valid;
                got_rsp.irq_level = rsp_if.irq_level;
                got_rsp.parity_mode = rsp_if.parity_mode;
                got_rsp.word_format = rsp_if.word_format;
                got_rsp.break_level = rsp_if.break_level;
                got_rsp.transmit_request = rsp_if.transmit_request;
                if (due_responses.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= SHOWN_ERRORS)
                        $display("%0t: response with nothing outstanding: %p", $realtime,
                                 got_rsp);
                end
                else
                begin
                    want_rsp = due_responses.pop_front();
                    n_checked++;
                    if (got_rsp !== want_rsp)
                    begin
                        n_errors++;
                        if (n_errors <= SHOWN_ERRORS)
                        begin
                            $display("%0t: response %0d mismatch", $realtime, n_checked);
                            $display("    expected %p", want_rsp);
                            $display("    actual   %p", got_rsp);
                        end
                    end
                end
                recv_gap = draw_pause(recv_calm);
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned roll;
        kind_t       kind;
        req_if.valid = 1'b0;
        req_if.kind = KIND_RX;
        req_if.data = 8'h00;
        req_if.select_level = 1'b0;
        rsp_if.ready = 1'b0;

        queue_event(KIND_READ, 8'h00, 1'b0);
        queue_event(KIND_SELECT, 8'h00, 1'b1);
        queue_event(KIND_READ, 8'hFF, 1'b0);
        queue_event(KIND_WRITE, 8'h00, 1'b1);
        queue_event(KIND_WRITE, 8'hFF, 1'b0);
        queue_event(KIND_WRITE, 8'h80, 1'b0);
        queue_event(KIND_WRITE, 8'h7E, 1'b0);
        queue_event(KIND_RX, 8'h00, 1'b1);
        queue_event(KIND_RX, 8'hFF, 1'b0);
        queue_event(KIND_READ, 8'h00, 1'b0);
        queue_event(KIND_RX, 8'hA5, 1'b0);
        queue_event(KIND_SELECT, 8'hFF, 1'b0);
        queue_event(KIND_WRITE, 8'hFF, 1'b1);
        queue_event(KIND_WRITE, 8'h00, 1'b0);
        queue_event(KIND_READ, 8'h00, 1'b0);
        queue_event(KIND_READ, 8'h00, 1'b0);
        queue_event(KIND_SELECT, 8'h5A, 1'b1);
        queue_event(KIND_READ, 8'h00, 1'b0);
        queue_event(KIND_RX, 8'h5A, 1'b0);
        queue_event(KIND_WRITE, 8'h1D, 1'b0);
        queue_event(KIND_WRITE, 8'hE0, 1'b0);
        queue_event(KIND_WRITE, 8'hFF, 1'b0);
        queue_event(KIND_WRITE, 8'h02, 1'b0);
        queue_event(KIND_READ, 8'h00, 1'b0);

        for (int unsigned i = 0; i < RANDOM_EVENTS; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 30)
                kind = KIND_RX;
            else if (roll < 60)
                kind = KIND_READ;
            else if (roll < 85)
                kind = KIND_WRITE;
            else
                kind = KIND_SELECT;
            queue_event(kind, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                        (i % 150) == 0);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (event_backlog.size() > 0 || req_if.valid || due_responses.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Run covered %0d transfers: %0d reads, %0d transmitted bytes,", n_sent,
                 n_reads, n_tx);
        $display("%0d locked control writes, %0d overruns; %0d checked, %0d mismatches",
                 n_locked, n_overruns, n_checked, n_errors);
        if (n_errors == 0 && due_responses.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
